/* design/lobm_pkg.sv */
// Shared types and constants for the limit order book matcher.
package lobm_pkg;

   localparam int DEF_PRICE_LEVELS = 1024;
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int ID_W             = 32;
   localparam int VOL_W            = 32;
   localparam int TICK_W           = 10;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef enum logic [1:0] {
      KIND_FILL   = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_REST   = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LVL,
      S_QRD,
      S_FILL,
      S_SCAN,
      S_OWN_ISSUE,
      S_OWN_DATA,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [VOL_W-1:0] vol;
   } q_entry_type;

   typedef struct packed {
      logic             lt;    // taker volume below maker volume
      logic [VOL_W-1:0] fill;  // smaller of the two
      logic [VOL_W-1:0] diff;  // larger minus smaller
   } alu_res_type;

endpackage

/* design/lobm_alu.sv */
// Shared volume compare and subtract unit.
module lobm_alu
   import lobm_pkg::*;
(
   input  logic [VOL_W-1:0] taker_vol,
   input  logic [VOL_W-1:0] maker_vol,
   output alu_res_type      res
);

   always_comb begin
      res.lt   = taker_vol < maker_vol;
      res.fill = res.lt ? taker_vol : maker_vol;
      res.diff = res.lt ? (maker_vol - taker_vol) : (taker_vol - maker_vol);
   end

endmodule

/* design/lobm_book.sv */
// One side of the book: per-level head/count table and the offer queue store.
module lobm_book
   import lobm_pkg::*;
#(
   parameter int PRICE_LEVELS = DEF_PRICE_LEVELS,
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        lvl_rd_en,
   input  logic [$clog2(PRICE_LEVELS)-1:0] lvl_rd_addr,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] lvl_rd_head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] lvl_rd_cnt,
   input  logic                        lvl_wr_en,
   input  logic [$clog2(PRICE_LEVELS)-1:0] lvl_wr_addr,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] lvl_wr_head,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] lvl_wr_cnt,
   input  logic                        q_rd_en,
   input  logic [$clog2(PRICE_LEVELS)+((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0]
                                       q_rd_addr,
   output q_entry_type                 q_rd_data,
   input  logic                        q_wr_en,
   input  logic [$clog2(PRICE_LEVELS)+((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0]
                                       q_wr_addr,
   input  q_entry_type                 q_wr_data
);

   localparam int LW = $clog2(PRICE_LEVELS);
   localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [SW+CW-1:0] lvl_mem [PRICE_LEVELS];
   q_entry_type      q_mem   [2**(LW+SW)];
   logic [SW+CW-1:0] lvl_rd_ff;
   q_entry_type      q_rd_ff;

   always_ff @(posedge clock) begin
      if (lvl_wr_en) begin
         lvl_mem[lvl_wr_addr] <= {lvl_wr_head, lvl_wr_cnt};
      end
      if (lvl_rd_en) begin
         lvl_rd_ff <= lvl_mem[lvl_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         q_mem[q_wr_addr] <= q_wr_data;
      end
      if (q_rd_en) begin
         q_rd_ff <= q_mem[q_rd_addr];
      end
   end

   assign lvl_rd_head = lvl_rd_ff[SW+CW-1:CW];
   assign lvl_rd_cnt  = lvl_rd_ff[CW-1:0];
   assign q_rd_data   = q_rd_ff;

endmodule

/* design/limit_order_book_matcher.sv */
// Top level: sequencer of the price-time priority limit order book matcher.
//
// channel | dir | fields (lowest bit first)
// req     | in  | tdata: order_id[31:0] price_tick[41:32] quantity[73:42]; tuser: side
// rsp     | out | tdata: maker_id[31:0] taker_id[63:32] exec_price[73:64]
//         |     |        exec_volume[105:74]; tuser: kind; tlast: last
//
// Operation: after reset a clearing pass zeroes both level tables with req_tready
// low. An order then reads the opposite level, fills its resting offers one at a
// time through one shared compare/subtract unit, then reads its own level to rest.
// Emptying a level triggers a best-price rescan of the opposite level table,
// one level per cycle through its single read port. The block holds one order
// at a time; a stalled rsp channel stalls the sequencer at the next result, and
// the next request is taken while the last result of an order still waits in
// the output register.
module limit_order_book_matcher
   import lobm_pkg::*;
#(
   parameter int PRICE_LEVELS = DEF_PRICE_LEVELS,
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // order_id, price_tick, quantity, zero pad
   input  logic         req_tuser,   // side
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // maker_id, taker_id, exec_price, exec_volume, pad
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast
);

   localparam int LW = $clog2(PRICE_LEVELS);
   localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // request fields
   logic [ID_W-1:0]   req_id;
   logic [TICK_W-1:0] req_tick;
   logic [VOL_W-1:0]  req_qty;
   assign req_id   = req_tdata[31:0];
   assign req_tick = req_tdata[41:32];
   assign req_qty  = req_tdata[73:42];

   // book ports, indexed by side (0 buy, 1 sell)
   logic             lvl_rd_en   [2];
   logic [LW-1:0]    lvl_rd_addr [2];
   logic [SW-1:0]    lvl_rd_head [2];
   logic [CW-1:0]    lvl_rd_cnt  [2];
   logic             lvl_wr_en   [2];
   logic [LW-1:0]    lvl_wr_addr [2];
   logic [SW-1:0]    lvl_wr_head [2];
   logic [CW-1:0]    lvl_wr_cnt  [2];
   logic             q_rd_en     [2];
   logic [LW+SW-1:0] q_rd_addr   [2];
   q_entry_type      q_rd_data   [2];
   logic             q_wr_en     [2];
   logic [LW+SW-1:0] q_wr_addr   [2];
   q_entry_type      q_wr_data   [2];

   for (genvar g = 0; g < 2; g++) begin : g_book
      lobm_book #(
         .PRICE_LEVELS (PRICE_LEVELS),
         .QUEUE_DEPTH  (QUEUE_DEPTH)
      ) u_book (
         .clock       (clock),
         .lvl_rd_en   (lvl_rd_en[g]),
         .lvl_rd_addr (lvl_rd_addr[g]),
         .lvl_rd_head (lvl_rd_head[g]),
         .lvl_rd_cnt  (lvl_rd_cnt[g]),
         .lvl_wr_en   (lvl_wr_en[g]),
         .lvl_wr_addr (lvl_wr_addr[g]),
         .lvl_wr_head (lvl_wr_head[g]),
         .lvl_wr_cnt  (lvl_wr_cnt[g]),
         .q_rd_en     (q_rd_en[g]),
         .q_rd_addr   (q_rd_addr[g]),
         .q_rd_data   (q_rd_data[g]),
         .q_wr_en     (q_wr_en[g]),
         .q_wr_addr   (q_wr_addr[g]),
         .q_wr_data   (q_wr_data[g])
      );
   end

   // sequencer state
   state_type        state_ff, state_in;
   logic [LW-1:0]    clr_addr_ff, clr_addr_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic             side_ff, side_in;
   logic [LW-1:0]    price_ff, price_in;
   logic [VOL_W-1:0] vol_ff, vol_in;
   logic [SW-1:0]    ohead_ff, ohead_in;      // opposite level head
   logic [CW-1:0]    ocnt_ff, ocnt_in;        // opposite level count
   q_entry_type      maker_ff, maker_in;
   logic [SW-1:0]    mhead_ff, mhead_in;      // own level head
   logic [CW-1:0]    mcnt_ff, mcnt_in;        // own level count
   logic             bid_valid_ff, bid_valid_in;
   logic [LW-1:0]    bid_ff, bid_in;
   logic             ask_valid_ff, ask_valid_in;
   logic [LW-1:0]    ask_ff, ask_in;
   logic [LW-1:0]    scan_addr_ff, scan_addr_in;
   logic             scan_more_ff, scan_more_in;
   logic             pend_ff, pend_in;
   logic [LW-1:0]    pend_addr_ff, pend_addr_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         out_kind_ff, out_kind_in;
   logic [ID_W-1:0]  out_maker_ff, out_maker_in;
   logic [ID_W-1:0]  out_taker_ff, out_taker_in;
   logic [LW-1:0]    out_price_ff, out_price_in;
   logic [VOL_W-1:0] out_vol_ff, out_vol_in;
   logic             out_last_ff, out_last_in;

   alu_res_type      alu;
   lobm_alu u_alu (
      .taker_vol (vol_ff),
      .maker_vol (maker_ff.vol),
      .res       (alu)
   );

   logic             opp, own;
   logic             out_free;
   logic [LW-1:0]    tick_sat;
   logic [SW-1:0]    head_next;
   logic [CW-1:0]    cnt_next;
   logic [VOL_W-1:0] vol_next;
   logic [SW:0]      tail_sum;
   logic [SW-1:0]    tail_slot;
   logic             scan_hit;
   logic             scan_end;

   assign opp      = ~side_ff;
   assign own      = side_ff;
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      if ({22'd0, req_tick} >= 32'(PRICE_LEVELS)) begin
         tick_sat = LW'(PRICE_LEVELS - 1);
      end else begin
         tick_sat = LW'(req_tick);
      end
      head_next = (ohead_ff == SW'(QUEUE_DEPTH - 1)) ? '0 : ohead_ff + 1'b1;
      cnt_next  = alu.lt ? ocnt_ff : ocnt_ff - 1'b1;
      vol_next  = alu.lt ? '0 : alu.diff;
      tail_sum  = (SW+1)'(mhead_ff) + (SW+1)'(mcnt_ff);
      if (tail_sum >= (SW+1)'(QUEUE_DEPTH)) begin
         tail_slot = SW'(tail_sum - (SW+1)'(QUEUE_DEPTH));
      end else begin
         tail_slot = SW'(tail_sum);
      end
      scan_hit = pend_ff & (lvl_rd_cnt[opp] != '0);
      // buy takers rescan asks upward, sell takers rescan bids downward
      scan_end = (side_ff == SIDE_BUY) ? (scan_addr_ff == LW'(PRICE_LEVELS - 1))
                                       : (scan_addr_ff == '0);
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      id_in        = id_ff;
      side_in      = side_ff;
      price_in     = price_ff;
      vol_in       = vol_ff;
      ohead_in     = ohead_ff;
      ocnt_in      = ocnt_ff;
      maker_in     = maker_ff;
      mhead_in     = mhead_ff;
      mcnt_in      = mcnt_ff;
      bid_valid_in = bid_valid_ff;
      bid_in       = bid_ff;
      ask_valid_in = ask_valid_ff;
      ask_in       = ask_ff;
      scan_addr_in = scan_addr_ff;
      scan_more_in = scan_more_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      out_kind_in  = out_kind_ff;
      out_maker_in = out_maker_ff;
      out_taker_in = out_taker_ff;
      out_price_in = out_price_ff;
      out_vol_in   = out_vol_ff;
      out_last_in  = out_last_ff;
      req_tready   = 1'b0;
      for (int s = 0; s < 2; s++) begin
         lvl_rd_en[s]   = 1'b0;
         lvl_rd_addr[s] = price_ff;
         lvl_wr_en[s]   = 1'b0;
         lvl_wr_addr[s] = price_ff;
         lvl_wr_head[s] = head_next;
         lvl_wr_cnt[s]  = cnt_next;
         q_rd_en[s]     = 1'b0;
         q_rd_addr[s]   = {price_ff, ohead_ff};
         q_wr_en[s]     = 1'b0;
         q_wr_addr[s]   = {price_ff, ohead_ff};
         q_wr_data[s]   = '{id: maker_ff.id, vol: alu.diff};
      end

      case (state_ff)
         S_CLEAR: begin
            for (int s = 0; s < 2; s++) begin
               lvl_wr_en[s]   = 1'b1;
               lvl_wr_addr[s] = clr_addr_ff;
               lvl_wr_head[s] = '0;
               lvl_wr_cnt[s]  = '0;
            end
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LW'(PRICE_LEVELS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               id_in   = req_id;
               side_in = req_tuser;
               vol_in  = req_qty;
               price_in = tick_sat;
               if (req_tuser == SIDE_BUY) begin
                  if (ask_valid_ff && ask_ff < tick_sat) begin
                     price_in = ask_ff;
                  end
               end else begin
                  if (bid_valid_ff && bid_ff > tick_sat) begin
                     price_in = bid_ff;
                  end
               end
               state_in = S_LVL;
            end
         end
         S_LVL: begin
            // read the opposite level this cycle; data shows up next state
            lvl_rd_en[opp] = 1'b1;
            state_in       = S_QRD;
         end
         S_QRD: begin
            // pick up head/count of the opposite level
            ohead_in = lvl_rd_head[opp];
            ocnt_in  = lvl_rd_cnt[opp];
            if (vol_ff != '0 && lvl_rd_cnt[opp] != '0) begin
               q_rd_en[opp]   = 1'b1;
               q_rd_addr[opp] = {price_ff, lvl_rd_head[opp]};
               state_in       = S_FILL;
            end else begin
               state_in = S_OWN_ISSUE;
            end
         end
         S_FILL: begin
            // queue data valid from here on (read port is idle meanwhile)
            maker_in = q_rd_data[opp];
            state_in = S_SCAN;
            pend_in  = 1'b0;
            scan_more_in = 1'b0;
         end
         S_SCAN: begin
            if (scan_more_ff || pend_ff) begin
               // best-price rescan of the opposite table
               if (scan_hit) begin
                  if (side_ff == SIDE_BUY) begin
                     ask_valid_in = 1'b1;
                     ask_in       = pend_addr_ff;
                  end else begin
                     bid_valid_in = 1'b1;
                     bid_in       = pend_addr_ff;
                  end
                  pend_in      = 1'b0;
                  scan_more_in = 1'b0;
                  state_in     = S_OWN_ISSUE;
               end else if (scan_more_ff) begin
                  lvl_rd_en[opp]   = 1'b1;
                  lvl_rd_addr[opp] = scan_addr_ff;
                  pend_in          = 1'b1;
                  pend_addr_in     = scan_addr_ff;
                  scan_more_in     = ~scan_end;
                  scan_addr_in     = (side_ff == SIDE_BUY) ? scan_addr_ff + 1'b1
                                                           : scan_addr_ff - 1'b1;
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_OWN_ISSUE;
               end
            end else if (out_free) begin
               // one fill against the maker at the head of the level
               rsp_valid_in = 1'b1;
               out_kind_in  = KIND_FILL;
               out_maker_in = maker_ff.id;
               out_taker_in = id_ff;
               out_price_in = price_ff;
               out_vol_in   = alu.fill;
               out_last_in  = 1'b0;
               vol_in       = vol_next;
               lvl_wr_en[opp] = 1'b1;
               if (alu.lt) begin
                  q_wr_en[opp]   = 1'b1;
                  lvl_wr_head[opp] = ohead_ff;
               end else begin
                  ohead_in = head_next;
               end
               ocnt_in = cnt_next;
               if (vol_next != '0 && cnt_next != '0) begin
                  q_rd_en[opp]   = 1'b1;
                  q_rd_addr[opp] = {price_ff, head_next};
                  ohead_in       = head_next;
                  state_in       = S_FILL;
               end else if (cnt_next == '0) begin
                  if (side_ff == SIDE_BUY) begin
                     ask_valid_in = 1'b0;
                     ask_in       = '0;
                     scan_addr_in = price_ff + 1'b1;
                     scan_more_in = (price_ff != LW'(PRICE_LEVELS - 1));
                  end else begin
                     bid_valid_in = 1'b0;
                     bid_in       = '0;
                     scan_addr_in = price_ff - 1'b1;
                     scan_more_in = (price_ff != '0);
                  end
                  pend_in  = 1'b0;
                  state_in = (scan_more_in) ? S_SCAN : S_OWN_ISSUE;
               end else begin
                  state_in = S_OWN_ISSUE;
               end
            end
         end
         S_OWN_ISSUE: begin
            lvl_rd_en[own] = 1'b1;
            state_in       = S_OWN_DATA;
         end
         S_OWN_DATA: begin
            mhead_in = lvl_rd_head[own];
            mcnt_in  = lvl_rd_cnt[own];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_maker_in = '0;
               out_taker_in = id_ff;
               out_price_in = price_ff;
               out_vol_in   = vol_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
               if (vol_ff == '0) begin
                  out_kind_in = KIND_DONE;
               end else if (mcnt_ff >= CW'(QUEUE_DEPTH)) begin
                  out_kind_in = KIND_REJECT;
               end else begin
                  out_kind_in      = KIND_REST;
                  q_wr_en[own]     = 1'b1;
                  q_wr_addr[own]   = {price_ff, tail_slot};
                  q_wr_data[own]   = '{id: id_ff, vol: vol_ff};
                  lvl_wr_en[own]   = 1'b1;
                  lvl_wr_head[own] = mhead_ff;
                  lvl_wr_cnt[own]  = mcnt_ff + 1'b1;
                  if (side_ff == SIDE_BUY) begin
                     if (!bid_valid_ff || price_ff > bid_ff) begin
                        bid_valid_in = 1'b1;
                        bid_in       = price_ff;
                     end
                  end else begin
                     if (!ask_valid_ff || price_ff < ask_ff) begin
                        ask_valid_in = 1'b1;
                        ask_in       = price_ff;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         bid_valid_ff <= 1'b0;
         bid_ff       <= '0;
         ask_valid_ff <= 1'b0;
         ask_ff       <= '0;
         scan_more_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         bid_valid_ff <= bid_valid_in;
         bid_ff       <= bid_in;
         ask_valid_ff <= ask_valid_in;
         ask_ff       <= ask_in;
         scan_more_ff <= scan_more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      side_ff      <= side_in;
      price_ff     <= price_in;
      vol_ff       <= vol_in;
      ohead_ff     <= ohead_in;
      ocnt_ff      <= ocnt_in;
      maker_ff     <= maker_in;
      mhead_ff     <= mhead_in;
      mcnt_ff      <= mcnt_in;
      scan_addr_ff <= scan_addr_in;
      pend_addr_ff <= pend_addr_in;
      out_kind_ff  <= out_kind_in;
      out_maker_ff <= out_maker_in;
      out_taker_ff <= out_taker_in;
      out_price_ff <= out_price_in;
      out_vol_ff   <= out_vol_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_vol_ff, TICK_W'(out_price_ff), out_taker_ff, out_maker_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // one order at a time: no request right after an accepted one
   a_one_order: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an order is in progress");

   // fills never close a run, completions always do
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_FILL) != rsp_tlast))
      else $error("tlast does not match result kind");

   // the book is never crossed
   a_not_crossed: assert property (@(posedge clock) disable iff (reset)
      (bid_valid_ff && ask_valid_ff) |-> (bid_ff < ask_ff))
      else $error("best bid at or above best ask");
`endif

endmodule

/* test/limit_order_book_matcher_tb.sv */
// Testbench for the limit order book matcher: directed and random order streams.
`timescale 1ns / 100ps

module limit_order_book_matcher_tb;
   import lobm_pkg::*;

   localparam int LEVELS    = DEF_PRICE_LEVELS;
   localparam int DEPTH     = DEF_QUEUE_DEPTH;
   localparam int DUE_DEPTH = 1024;

   typedef struct {
      kind_type    kind;
      logic [31:0] maker;
      logic [31:0] taker;
      logic [9:0]  price;
      logic [31:0] volume;
      logic        last;
   } trade_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   // book shadow: index 0 buys, 1 sells
   logic [63:0] book_slots [2][LEVELS*DEPTH];
   int          book_head  [2][LEVELS];
   int          book_count [2][LEVELS];
   logic        bid_ok = 1'b0, ask_ok = 1'b0;
   int          bid_px = 0, ask_px = 0;

   // expected results, ring buffer
   trade_type   trades_due [DUE_DEPTH];
   int          due_wr = 0;
   int          due_rd = 0;
   int          errors = 0;
   int          orders_sent = 0;
   int          trades_seen = 0;
   int          fills_seen = 0;
   int          rejects_seen = 0;
   int          hold_len = 0;

   limit_order_book_matcher dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // best price search after a level runs dry
   task automatic rescan_best(input int s);
      if (s == 1) begin
         ask_ok = 1'b0; ask_px = 0;
         for (int p = 0; p < LEVELS; p++) begin
            if (book_count[1][p] != 0) begin
               ask_ok = 1'b1; ask_px = p; break;
            end
         end
      end else begin
         bid_ok = 1'b0; bid_px = 0;
         for (int p = LEVELS - 1; p >= 0; p--) begin
            if (book_count[0][p] != 0) begin
               bid_ok = 1'b1; bid_px = p; break;
            end
         end
      end
   endtask

   task automatic push_trade(input kind_type k, input logic [31:0] mk, input logic [31:0] tk,
                             input int p, input logic [31:0] v, input logic l);
      trade_type t;
      t.kind = k; t.maker = mk; t.taker = tk; t.price = p[9:0]; t.volume = v; t.last = l;
      trades_due[due_wr % DUE_DEPTH] = t;
      due_wr++;
   endtask

   // match one taker against the book and queue its trades
   task automatic match_order(input logic [31:0] id, input logic side, input logic [9:0] tick,
                              input logic [31:0] qty);
      int          p, own, opp, n, slot;
      logic [31:0] vol, mid, mv;
      p = tick; vol = qty; n = 0;
      own = (side == SIDE_SELL) ? 1 : 0;
      opp = 1 - own;
      if (side == SIDE_BUY) begin
         if (ask_ok && ask_px < p) p = ask_px;
      end else begin
         if (bid_ok && bid_px > p) p = bid_px;
      end
      while (vol != 0 && book_count[opp][p] > 0 && n < DEPTH) begin
         slot = p * DEPTH + book_head[opp][p];
         mid = book_slots[opp][slot][63:32];
         mv  = book_slots[opp][slot][31:0];
         n++;
         if (vol < mv) begin
            push_trade(KIND_FILL, mid, id, p, vol, 1'b0);
            book_slots[opp][slot] = {mid, mv - vol};
            vol = 0;
         end else begin
            push_trade(KIND_FILL, mid, id, p, mv, 1'b0);
            vol -= mv;
            book_head[opp][p] = (book_head[opp][p] + 1) % DEPTH;
            book_count[opp][p]--;
            if (book_count[opp][p] == 0) rescan_best(opp);
         end
      end
      if (vol == 0) begin
         push_trade(KIND_DONE, '0, id, p, '0, 1'b1);
      end else if (book_count[own][p] >= DEPTH) begin
         push_trade(KIND_REJECT, '0, id, p, vol, 1'b1);
      end else begin
         slot = p * DEPTH + (book_head[own][p] + book_count[own][p]) % DEPTH;
         book_slots[own][slot] = {id, vol};
         book_count[own][p]++;
         if (own == 0) begin
            if (!bid_ok || p > bid_px) begin bid_ok = 1'b1; bid_px = p; end
         end else begin
            if (!ask_ok || p < ask_px) begin ask_ok = 1'b1; ask_px = p; end
         end
         push_trade(KIND_REST, '0, id, p, vol, 1'b1);
      end
   endtask

   // offer one order request; valid stays high across back-to-back requests
   task automatic send_order(input logic [31:0] id, input logic side, input logic [9:0] tick,
                             input logic [31:0] qty);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0 && req_tvalid) begin
         req_tvalid <= 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, qty, tick, id};
      req_tuser  <= side;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      match_order(id, side, tick, qty);
      orders_sent++;
   endtask

   // drop valid and wait for the book to answer everything
   task automatic drain_book();
      if (req_tvalid) req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_wr != due_rd) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_qty();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 32'd0;
      if (r < 12) return $urandom;
      return $urandom_range(1, 60);
   endfunction

   task automatic test_extremes();
      send_order(32'h0000_0000, SIDE_BUY, 10'd0, 32'd1);
      send_order(32'hFFFF_FFFF, SIDE_SELL, 10'd1023, 32'hFFFF_FFFF);
      send_order(32'h0000_0001, SIDE_BUY, 10'd500, 32'd0);          // zero quantity
      send_order(32'h0000_0002, SIDE_SELL, 10'd0, 32'd2);           // fills bid, bid empties
      send_order(32'h0000_0003, SIDE_BUY, 10'd1023, 32'hFFFF_FFFF); // sweeps the best ask
      send_order(32'h0000_0004, SIDE_SELL, 10'd1023, 32'd0);
      send_order(32'hA5A5_5A5A, SIDE_BUY, 10'd1023, 32'h8000_0000);
      drain_book();
   endtask

   task automatic test_queue_full();
      // 16 bids fill level 300, the 17th is rejected
      for (int i = 0; i < DEPTH + 1; i++)
         send_order(32'h1000 + i, SIDE_BUY, 10'd300, 32'd5);
      // one sell walks all 16 makers then rests: the longest run of trades
      send_order(32'h2000, SIDE_SELL, 10'd300, 32'd200);
      drain_book();
   endtask

   task automatic test_backpressure();
      hold_len = 400;
      for (int i = 0; i < 20; i++)
         send_order($urandom, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                    rand_qty());
      drain_book();
   endtask

   task automatic test_random_flow(input int count);
      int          base;
      logic [9:0]  tick;
      for (int i = 0; i < count; i++) begin
         base = 480 + 40 * (i / 80);
         if ($urandom_range(0, 9) == 0) tick = 10'($urandom);
         else tick = 10'(base + $urandom_range(0, 12));
         send_order($urandom, 1'($urandom_range(0, 1)), tick, rand_qty());
         if (i % 90 == 89) drain_book(); // sender pause until book quiet
      end
      drain_book();
   endtask

   // rsp_tready: random stall per result, plus one long hold-off on request
   initial begin
      int n;
      repeat (12) @(posedge clock);
      forever begin
         if (hold_len > 0) begin
            n = hold_len;
            hold_len = 0;
         end else begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      trade_type t;
      if (!reset && rsp_tvalid && rsp_tready) begin
         trades_seen++;
         if (due_wr == due_rd) begin
            $error("unexpected result kind=%0d", rsp_tuser);
            errors++;
         end else begin
            t = trades_due[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_tuser !== t.kind) begin
               $error("kind: expected %0d, actual %0d", t.kind, rsp_tuser); errors++;
            end
            if (rsp_tdata[31:0] !== t.maker) begin
               $error("maker_id: expected %h, actual %h", t.maker, rsp_tdata[31:0]); errors++;
            end
            if (rsp_tdata[63:32] !== t.taker) begin
               $error("taker_id: expected %h, actual %h", t.taker, rsp_tdata[63:32]); errors++;
            end
            if (rsp_tdata[73:64] !== t.price) begin
               $error("exec_price: expected %0d, actual %0d", t.price, rsp_tdata[73:64]);
               errors++;
            end
            if (rsp_tdata[105:74] !== t.volume) begin
               $error("exec_volume: expected %0d, actual %0d", t.volume, rsp_tdata[105:74]);
               errors++;
            end
            if (rsp_tlast !== t.last) begin
               $error("last: expected %0d, actual %0d", t.last, rsp_tlast); errors++;
            end
            if (t.kind == KIND_FILL) fills_seen++;
            if (t.kind == KIND_REJECT) rejects_seen++;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      for (int s = 0; s < 2; s++)
         for (int p = 0; p < LEVELS; p++) begin
            book_head[s][p] = 0;
            book_count[s][p] = 0;
         end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_queue_full();
      test_backpressure();
      test_random_flow(240);
      repeat (1100) @(posedge clock);
      $display("Sent %0d orders, checked %0d results (%0d fills, %0d queue-full rejects).",
               orders_sent, trades_seen, fills_seen, rejects_seen);
      $display("Covered price extremes, zero volume, full queues, level sweeps and backpressure.");
      if (errors == 0 && due_wr == due_rd) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
